### hdl/fbc_pkg.sv
// Shared types and constants for the frustum box cull block.
package fbc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    // Three full products plus the scaled offset need two guard bits.
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int IN_DATA_W   = 328;
    localparam int OUT_DATA_W  = 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;
    typedef t_coord [2:0]                  t_vec3;

    typedef struct packed {
        t_vec3  n;
        t_coord w;
    } t_plane;

    typedef struct packed {
        t_vec3 bmin;
        t_vec3 bmax;
    } t_box;

    typedef enum logic [1:0] {
        CMD_LOAD_PLANE  = 2'd0,
        CMD_LOAD_CORNER = 2'd1,
        CMD_TEST_BOX    = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PLANE  = 2'd1,
        KIND_CORNER = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

endpackage

### hdl/frustum_box_cull.sv
// Top level of the frustum box cull block: stores, corner test and pipeline control.
//
//  Channel | Dir | Handshake              | Payload
//  --------+-----+------------------------+-------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tuser command; tdata entry, coefs, box
//  m       | out | o_m_tvalid/i_m_tready  | tuser reject_kind; tdata visible
//
// One box enters per cycle while the output is not stalled; its result passes through the
// input register, operand select, multiply, then sum and output register stages in turn.
// The three 32x32 multipliers per plane set the stage depth.
// Reset clears the stores and the valid bits. A stall on the output freezes
// every stage at once, so nothing is lost or repeated; loads write the stores
// at their own transaction and are seen by every later test.
module frustum_box_cull import fbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0: entry[2:0], coef_x, coef_y, coef_z, coef_w,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero fill.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Fields from bit 0: visible, zero fill.
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Fields from bit 0: reject_kind[1:0].
    output logic [1:0]            o_m_tuser
);

    logic   en;
    logic   accept;
    t_cmd   cmd;
    logic [2:0] entry;
    t_vec3  coef;
    t_coord coef_w;
    t_box   in_box;

    t_plane r_plane  [NUM_PLANES];
    t_vec3  r_corner [NUM_CORNERS];

    logic   r1_v, r2_v, r3_v, r4_v;
    t_box   r1_box;
    logic   n_corner_rej;
    logic   r2_corner, r3_corner, r4_corner;
    logic [NUM_PLANES-1:0] plane_rej;
    t_kind  kind;

    // The whole pipeline moves together unless a finished result is held.
    assign en         = !r4_v || i_m_tready;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;

    assign cmd    = t_cmd'(i_s_tuser);
    assign entry  = i_s_tdata[2:0];
    assign coef[0] = i_s_tdata[34:3];
    assign coef[1] = i_s_tdata[66:35];
    assign coef[2] = i_s_tdata[98:67];
    assign coef_w  = i_s_tdata[130:99];
    assign in_box.bmin[0] = i_s_tdata[162:131];
    assign in_box.bmin[1] = i_s_tdata[194:163];
    assign in_box.bmin[2] = i_s_tdata[226:195];
    assign in_box.bmax[0] = i_s_tdata[258:227];
    assign in_box.bmax[1] = i_s_tdata[290:259];
    assign in_box.bmax[2] = i_s_tdata[322:291];

    // Plane and corner stores. Plane entries six and seven do not exist, so
    // such loads fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) r_plane[p] <= '0;
            for (int i = 0; i < NUM_CORNERS; i++) r_corner[i] <= '0;
        end else if (accept) begin
            case (cmd)
                CMD_LOAD_PLANE: begin
                    for (int p = 0; p < NUM_PLANES; p++) begin
                        if (entry == 3'(p)) begin
                            r_plane[p].n <= coef;
                            r_plane[p].w <= coef_w;
                        end
                    end
                end
                CMD_LOAD_CORNER: begin
                    r_corner[entry] <= coef;
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits travel with the tests; loads and the unused command stop here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid && (cmd == CMD_TEST_BOX);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_box <= in_box;
        end
    end

    // Corner test: all eight frustum corners strictly beyond one box face.
    always_comb begin
        logic all_above;
        logic all_below;
        n_corner_rej = 1'b0;
        for (int k = 0; k < 3; k++) begin
            all_above = 1'b1;
            all_below = 1'b1;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                if (!(signed'(r1_box.bmax[k]) < signed'(r_corner[i][k]))) all_above = 1'b0;
                if (!(signed'(r_corner[i][k]) < signed'(r1_box.bmin[k]))) all_below = 1'b0;
            end
            if (all_above || all_below) n_corner_rej = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_corner <= n_corner_rej;
            r3_corner <= r2_corner;
            r4_corner <= r3_corner;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fbc_plane u_plane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_plane  (r_plane[p]),
            .i_box    (r1_box),
            .o_reject (plane_rej[p])
        );
    end

    // The plane test takes precedence over the corner test.
    always_comb begin
        if (|plane_rej) begin
            kind = KIND_PLANE;
        end else if (r4_corner) begin
            kind = KIND_CORNER;
        end else begin
            kind = KIND_NONE;
        end
    end

    assign o_m_tvalid = r4_v;
    assign o_m_tuser  = kind;
    assign o_m_tdata  = OUT_DATA_W'(kind == KIND_NONE);

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_NONE || o_m_tuser == KIND_PLANE ||
                        o_m_tuser == KIND_CORNER))
        else $error("reject kind out of range");

    a_visible_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tuser == KIND_NONE)))
        else $error("visible disagrees with reject kind");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !en) |=> r3_v)
        else $error("stalled stage lost its item");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_no_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd != CMD_TEST_BOX) |=> !r1_v)
        else $error("load produced a result");

endmodule

### hdl/fbc_plane.sv
// One plane's test: picks the box corner with the largest value, multiplies, sums.
module fbc_plane import fbc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_plane i_plane,
    input  t_box   i_box,
    output logic   o_reject
);

    t_vec3  n_sel;
    t_vec3  r_sel;
    t_vec3  r_n;
    t_coord r_w;
    t_coord r_w2;
    t_prod  r_prod [3];
    t_sum   n_sum;
    logic   r_reject;

    // The largest dot product over the eight corners takes, on each axis, the
    // larger coordinate for a non-negative normal and the smaller otherwise.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (signed'(i_plane.n[k]) >= 0) begin
                n_sel[k] = (signed'(i_box.bmax[k]) > signed'(i_box.bmin[k])) ?
                           i_box.bmax[k] : i_box.bmin[k];
            end else begin
                n_sel[k] = (signed'(i_box.bmax[k]) < signed'(i_box.bmin[k])) ?
                           i_box.bmax[k] : i_box.bmin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
            r_n   <= i_plane.n;
            r_w   <= i_plane.w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= signed'(r_n[k]) * signed'(r_sel[k]);
            end
            r_w2 <= r_w;
        end
    end

    always_comb begin
        n_sum = t_sum'(r_prod[0]) + t_sum'(r_prod[1]) + t_sum'(r_prod[2])
              + (t_sum'(r_w2) <<< FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_reject <= n_sum[SUM_WIDTH-1];
        end
    end

    assign o_reject = r_reject;

endmodule
